// ===== hdl/display_crop_to_storage_rect_macros.svh =====
// Assertion macros used by the checker file of the crop remap block.
// Depends on nothing; include by bare file name.
`ifndef DISPLAY_CROP_TO_STORAGE_RECT_MACROS_SVH
`define DISPLAY_CROP_TO_STORAGE_RECT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define DCSR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dcsr assertion failed");

// Condition that must never be true at a clock edge.
`define DCSR_NEVER(lbl, clk, rst_n, cond) \
    `DCSR_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ===== hdl/dcsr_pkg.sv =====
// Types, register indexes, orientation and status codes of the crop remap block.
// Depends on nothing.
package dcsr_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_ORIENT = 2'd0;
    localparam reg_idx_t REG_WIDTH  = 2'd1;
    localparam reg_idx_t REG_HEIGHT = 2'd2;

    typedef logic [3:0] orient_t;
    localparam orient_t ORIENT_NORMAL     = 4'd1;
    localparam orient_t ORIENT_MIRROR_H   = 4'd2;
    localparam orient_t ORIENT_ROT180     = 4'd3;
    localparam orient_t ORIENT_MIRROR_V   = 4'd4;
    localparam orient_t ORIENT_TRANSPOSE  = 4'd5;
    localparam orient_t ORIENT_ROT90      = 4'd6;
    localparam orient_t ORIENT_TRANSVERSE = 4'd7;
    localparam orient_t ORIENT_ROT270     = 4'd8;

    typedef logic [2:0] status_t;
    localparam status_t STATUS_OK         = 3'd0;
    localparam status_t STATUS_BAD_ORIENT = 3'd1;
    localparam status_t STATUS_EMPTY      = 3'd2;
    localparam status_t STATUS_ORIGIN     = 3'd3;
    localparam status_t STATUS_SIZE       = 3'd4;

    typedef logic signed [33:0] coord34_t;
    typedef logic signed [34:0] coord35_t;

    typedef struct packed {
        orient_t     orient;
        logic [31:0] width;
        logic [31:0] height;
    } cfg_t;

    // Corner ranges, already routed to the storage axes.
    typedef struct packed {
        status_t     pre_status;
        logic        flip_x;
        logic        flip_y;
        coord34_t    lo_x;
        coord34_t    hi_x;
        coord34_t    lo_y;
        coord34_t    hi_y;
        logic [31:0] len_x;
        logic [31:0] len_y;
    } corner_t;

    // Bounding box in storage coordinates.
    typedef struct packed {
        status_t     pre_status;
        coord35_t    min_x;
        coord35_t    max_x;
        coord35_t    min_y;
        coord35_t    max_y;
        logic [31:0] len_x;
        logic [31:0] len_y;
    } bbox_t;

endpackage

// ===== hdl/dcsr_if.sv =====
// Valid/ready channel interfaces for crop requests and storage rectangles.
// Depends on dcsr_pkg.
interface dcsr_crop_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] crop_left;
    logic signed [31:0] crop_top;
    logic [31:0]        crop_width;
    logic [31:0]        crop_height;

    modport source (output valid, crop_left, crop_top, crop_width, crop_height,
                    input ready);
    modport sink (input valid, crop_left, crop_top, crop_width, crop_height,
                  output ready);
endinterface

interface dcsr_rect_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rect_left;
    logic signed [31:0] rect_top;
    logic [30:0]        rect_width;
    logic [30:0]        rect_height;
    dcsr_pkg::status_t  status;

    modport source (output valid, rect_left, rect_top, rect_width, rect_height, status,
                    input ready);
    modport sink (input valid, rect_left, rect_top, rect_width, rect_height, status,
                  output ready);
endinterface

// ===== hdl/dcsr_cfg.sv =====
// APB-style register file: orientation code and stored image size.
// Depends on dcsr_pkg.
module dcsr_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcsr_pkg::ADDR_W-1:0]   paddr,
    input  logic [dcsr_pkg::DATA_W-1:0]   pwdata,
    output logic [dcsr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output dcsr_pkg::cfg_t                cfg
);

    dcsr_pkg::cfg_t   cfg_reg;
    dcsr_pkg::cfg_t   cfg_next;
    dcsr_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                dcsr_pkg::REG_ORIENT: cfg_next.orient = pwdata[3:0];
                dcsr_pkg::REG_WIDTH:  cfg_next.width  = pwdata;
                dcsr_pkg::REG_HEIGHT: cfg_next.height = pwdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            dcsr_pkg::REG_ORIENT: prdata = {28'd0, cfg_reg.orient};
            dcsr_pkg::REG_WIDTH:  prdata = cfg_reg.width;
            dcsr_pkg::REG_HEIGHT: prdata = cfg_reg.height;
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.orient <= dcsr_pkg::ORIENT_NORMAL;
            cfg_reg.width  <= '0;
            cfg_reg.height <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/dcsr_corner.sv =====
// Stage 1: decode orientation, precheck, and form corner ranges per storage axis.
// Depends on dcsr_pkg and dcsr_crop_if.
module dcsr_corner
(
    input  logic                clk,
    input  logic                rst_n,
    input  dcsr_pkg::cfg_t      cfg,
    dcsr_crop_if.sink           crop,
    input  logic                down_ready,
    output logic                valid,
    output dcsr_pkg::corner_t   corner
);

    logic              valid_reg;
    dcsr_pkg::corner_t corner_reg;
    dcsr_pkg::corner_t corner_next;
    logic              swap;
    logic              flip_x;
    logic              flip_y;
    logic              orient_ok;
    dcsr_pkg::coord34_t lo_h;
    dcsr_pkg::coord34_t hi_h;
    dcsr_pkg::coord34_t lo_v;
    dcsr_pkg::coord34_t hi_v;
    logic              advance;

    assign crop.ready = !valid_reg || down_ready;
    assign advance    = crop.valid && crop.ready;
    assign valid      = valid_reg;
    assign corner     = corner_reg;

    always_comb
    begin
        orient_ok = 1'b1;
        swap      = 1'b0;
        flip_x    = 1'b0;
        flip_y    = 1'b0;
        case (cfg.orient)
            dcsr_pkg::ORIENT_NORMAL:     ;
            dcsr_pkg::ORIENT_MIRROR_H:   flip_x = 1'b1;
            dcsr_pkg::ORIENT_ROT180:
            begin
                flip_x = 1'b1;
                flip_y = 1'b1;
            end
            dcsr_pkg::ORIENT_MIRROR_V:   flip_y = 1'b1;
            dcsr_pkg::ORIENT_TRANSPOSE:  swap = 1'b1;
            dcsr_pkg::ORIENT_ROT90:
            begin
                swap   = 1'b1;
                flip_y = 1'b1;
            end
            dcsr_pkg::ORIENT_TRANSVERSE:
            begin
                swap   = 1'b1;
                flip_x = 1'b1;
                flip_y = 1'b1;
            end
            dcsr_pkg::ORIENT_ROT270:
            begin
                swap   = 1'b1;
                flip_x = 1'b1;
            end
            default:                     orient_ok = 1'b0;
        endcase
    end

    // Display-axis corner ranges: first and last pixel of each side.
    assign lo_h = {{2{crop.crop_left[31]}}, crop.crop_left};
    assign hi_h = lo_h + $signed({2'b00, crop.crop_width}) - 34'sd1;
    assign lo_v = {{2{crop.crop_top[31]}}, crop.crop_top};
    assign hi_v = lo_v + $signed({2'b00, crop.crop_height}) - 34'sd1;

    always_comb
    begin
        if (!orient_ok)
            corner_next.pre_status = dcsr_pkg::STATUS_BAD_ORIENT;
        else if (crop.crop_width == 32'd0 || crop.crop_height == 32'd0)
            corner_next.pre_status = dcsr_pkg::STATUS_EMPTY;
        else
            corner_next.pre_status = dcsr_pkg::STATUS_OK;
        corner_next.flip_x = flip_x;
        corner_next.flip_y = flip_y;
        // Transposing codes take the storage x range from the display rows.
        corner_next.lo_x  = swap ? lo_v : lo_h;
        corner_next.hi_x  = swap ? hi_v : hi_h;
        corner_next.lo_y  = swap ? lo_h : lo_v;
        corner_next.hi_y  = swap ? hi_h : hi_v;
        corner_next.len_x = swap ? crop.crop_height : crop.crop_width;
        corner_next.len_y = swap ? crop.crop_width : crop.crop_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (crop.ready)
            valid_reg <= crop.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            corner_reg <= corner_next;
    end

endmodule

// ===== hdl/dcsr_flip.sv =====
// Stage 2: mirror corner ranges against the stored size to get the bounding box.
// Depends on dcsr_pkg.
module dcsr_flip
(
    input  logic                clk,
    input  logic                rst_n,
    input  dcsr_pkg::cfg_t      cfg,
    input  logic                up_valid,
    output logic                up_ready,
    input  dcsr_pkg::corner_t   corner,
    input  logic                down_ready,
    output logic                valid,
    output dcsr_pkg::bbox_t     bbox
);

    logic               valid_reg;
    dcsr_pkg::bbox_t    bbox_reg;
    dcsr_pkg::bbox_t    bbox_next;
    dcsr_pkg::coord35_t w_m1;
    dcsr_pkg::coord35_t h_m1;
    dcsr_pkg::coord35_t lo_x;
    dcsr_pkg::coord35_t hi_x;
    dcsr_pkg::coord35_t lo_y;
    dcsr_pkg::coord35_t hi_y;

    assign up_ready = !valid_reg || down_ready;
    assign valid    = valid_reg;
    assign bbox     = bbox_reg;

    assign w_m1 = $signed({3'b000, cfg.width}) - 35'sd1;
    assign h_m1 = $signed({3'b000, cfg.height}) - 35'sd1;
    assign lo_x = {corner.lo_x[33], corner.lo_x};
    assign hi_x = {corner.hi_x[33], corner.hi_x};
    assign lo_y = {corner.lo_y[33], corner.lo_y};
    assign hi_y = {corner.hi_y[33], corner.hi_y};

    // A mirrored axis swaps the ends: the far display edge becomes the near one.
    always_comb
    begin
        bbox_next.pre_status = corner.pre_status;
        bbox_next.min_x = corner.flip_x ? w_m1 - hi_x : lo_x;
        bbox_next.max_x = corner.flip_x ? w_m1 - lo_x : hi_x;
        bbox_next.min_y = corner.flip_y ? h_m1 - hi_y : lo_y;
        bbox_next.max_y = corner.flip_y ? h_m1 - lo_y : hi_y;
        bbox_next.len_x = corner.len_x;
        bbox_next.len_y = corner.len_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            bbox_reg <= bbox_next;
    end

endmodule

// ===== hdl/dcsr_check.sv =====
// Stage 3: range checks, final status and the registered result.
// Depends on dcsr_pkg and dcsr_rect_if.
module dcsr_check
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  dcsr_pkg::bbox_t    bbox,
    dcsr_rect_if.source        rect
);

    logic               valid_reg;
    logic signed [31:0] left_reg;
    logic signed [31:0] top_reg;
    logic [30:0]        width_reg;
    logic [30:0]        height_reg;
    dcsr_pkg::status_t  status_reg;
    logic signed [31:0] left_next;
    logic signed [31:0] top_next;
    logic [30:0]        width_next;
    logic [30:0]        height_next;
    dcsr_pkg::status_t  status_next;
    logic               origin_bad;
    logic               size_bad;

    // A 35-bit value fits in 32 signed bits when its top four bits agree.
    function automatic logic fits32(input dcsr_pkg::coord35_t v);
        fits32 = (v[34:31] == 4'b0000) || (v[34:31] == 4'b1111);
    endfunction

    assign origin_bad = !fits32(bbox.min_x) || !fits32(bbox.max_x) ||
                        !fits32(bbox.min_y) || !fits32(bbox.max_y);
    // Mirroring keeps the extent, so the size is the routed crop length.
    assign size_bad = bbox.len_x[31] || bbox.len_y[31];

    always_comb
    begin
        left_next   = '0;
        top_next    = '0;
        width_next  = '0;
        height_next = '0;
        if (bbox.pre_status != dcsr_pkg::STATUS_OK)
            status_next = bbox.pre_status;
        else if (origin_bad)
            status_next = dcsr_pkg::STATUS_ORIGIN;
        else if (size_bad)
            status_next = dcsr_pkg::STATUS_SIZE;
        else
        begin
            status_next = dcsr_pkg::STATUS_OK;
            left_next   = bbox.min_x[31:0];
            top_next    = bbox.min_y[31:0];
            width_next  = bbox.len_x[30:0];
            height_next = bbox.len_y[30:0];
        end
    end

    assign up_ready         = !valid_reg || rect.ready;
    assign rect.valid       = valid_reg;
    assign rect.rect_left   = left_reg;
    assign rect.rect_top    = top_reg;
    assign rect.rect_width  = width_reg;
    assign rect.rect_height = height_reg;
    assign rect.status      = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            status_reg <= status_next;
        end
    end

endmodule

// ===== hdl/display_crop_to_storage_rect.sv =====
// Channel  | Dir | Handshake    | Payload
// crop     | in  | valid/ready  | crop_left, crop_top, crop_width, crop_height
// rect     | out | valid/ready  | rect_left, rect_top, rect_width, rect_height, status
// APB      | in  | psel/penable | orient_code @0x0, stored_width @0x4, stored_height @0x8
//
// Three register stages (corner ranges, mirror, range check): one transaction per
// cycle while rect does not stall; the 34/35-bit adders set the depth.
// Reset clears the valid bits and loads orientation 1 with a zero stored size.
// A stall on rect backs up stage by stage; crop ready drops only when all
// three stages hold a transaction. No transaction is dropped or repeated.
// Depends on dcsr_pkg, dcsr_if, dcsr_cfg, dcsr_corner, dcsr_flip, dcsr_check.
module display_crop_to_storage_rect
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dcsr_pkg::ADDR_W-1:0] paddr,
    input  logic [dcsr_pkg::DATA_W-1:0] pwdata,
    output logic [dcsr_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    dcsr_crop_if.sink                   crop,
    dcsr_rect_if.source                 rect
);

    dcsr_pkg::cfg_t    cfg;
    dcsr_pkg::corner_t corner;
    dcsr_pkg::bbox_t   bbox;
    logic              s1_valid;
    logic              s2_valid;
    logic              s2_ready;
    logic              s3_ready;

    dcsr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dcsr_corner u_corner
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .crop       (crop),
        .down_ready (s2_ready),
        .valid      (s1_valid),
        .corner     (corner)
    );

    dcsr_flip u_flip
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .up_valid   (s1_valid),
        .up_ready   (s2_ready),
        .corner     (corner),
        .down_ready (s3_ready),
        .valid      (s2_valid),
        .bbox       (bbox)
    );

    dcsr_check u_check
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s3_ready),
        .bbox     (bbox),
        .rect     (rect)
    );

endmodule

// ===== hdl/dcsr_checker.sv =====
// Port-level checks on the crop remap block, bound to its top level.
// Depends on dcsr_pkg and display_crop_to_storage_rect_macros.svh.
`include "display_crop_to_storage_rect_macros.svh"

module dcsr_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] rect_left,
    input logic signed [31:0] rect_top,
    input logic [30:0]        rect_width,
    input logic [30:0]        rect_height,
    input dcsr_pkg::status_t  status
);

    // A stalled result holds.
    `DCSR_ASSERT(a_stall_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable({rect_left, rect_top, rect_width, rect_height, status})))

    // Any error clears the rectangle.
    `DCSR_ASSERT(a_err_zero, clk, rst_n, (out_valid && (status != dcsr_pkg::STATUS_OK)) |-> (rect_left == 32'sd0 && rect_top == 32'sd0 && rect_width == 31'd0 && rect_height == 31'd0))

    // A good result never has an empty side.
    `DCSR_ASSERT(a_ok_nonempty, clk, rst_n, (out_valid && (status == dcsr_pkg::STATUS_OK)) |-> (rect_width != 31'd0 && rect_height != 31'd0))

    // Status codes stop at size out of range.
    `DCSR_NEVER(a_status_range, clk, rst_n, out_valid && (status > dcsr_pkg::STATUS_SIZE))

endmodule

bind display_crop_to_storage_rect dcsr_checker u_dcsr_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (rect.valid),
    .out_ready   (rect.ready),
    .rect_left   (rect.rect_left),
    .rect_top    (rect.rect_top),
    .rect_width  (rect.rect_width),
    .rect_height (rect.rect_height),
    .status      (rect.status)
);
